/* design/ipidfc_pkg.sv */
package ipidfc_pkg;

  // Multiplier datapath widths
  localparam int unsigned DIG_W   = 18;           // multiplier digit per cycle
  localparam int unsigned MAG_W   = 2 * DIG_W;    // operand magnitude, two digits
  localparam int unsigned MCAND_W = 31;           // gain or weight operand
  localparam int unsigned OPD_W   = 35;           // signed operand before magnitude split
  localparam int unsigned ACC_W   = 68;           // full product, signed

  // Blend weights are Q1.16
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned WEIGHT_ONE  = 65536;
  localparam int unsigned WEIGHT_W    = 17;

  localparam int unsigned DELTA_LIMIT_INT = 50;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_DERIV_SMOOTHING = 3'd3,
    REG_ERROR_SMOOTHING = 3'd4,
    REG_DRIVE_SMOOTHING = 3'd5,
    REG_DRIVE_LIMIT     = 3'd6
  } cfg_reg_e;

  // Request into the shared multiplier
  typedef struct packed {
    logic               start;
    logic               neg;         // operand sign
    logic               gain_shift;  // 1: drop FRAC_BITS, 0: drop WEIGHT_BITS
    logic [MAG_W-1:0]   mag;
    logic [MCAND_W-1:0] mcand;
  } mac_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] result;
  } mac_rsp_t;

  // Weight above one acts as one
  function automatic logic [MCAND_W-1:0] wclamp(input logic [WEIGHT_W-1:0] w);
    logic [MCAND_W-1:0] r;
    if (w > WEIGHT_W'(WEIGHT_ONE)) begin
      r = MCAND_W'(WEIGHT_ONE);
    end else begin
      r = MCAND_W'(w);
    end
    return r;
  endfunction

endpackage

/* design/incremental_pid_filtered_clamped.sv */
// Velocity-form PID controller with input, derivative and output smoothing,
// all in signed fixed point with FRAC_BITS fraction bits. Each accepted item
// is one error sample; it yields exactly one drive value. The sample is
// low-pass filtered, the P, I and D increments are formed from the filtered
// error history, D is smoothed again, the summed increment is clamped to
// +/-50, added to the last drive and clamped to +/-drive_limit, then blended
// with the last drive and clamped once more. Gain products and blends round
// toward minus infinity. All six multiplies run on one 18x31 multiplier
// that takes two digit steps plus a sign/shift step per product. An item
// holds the block from acceptance until its drive value moves into the
// output register, and in_ready_o is high only while the block is idle.
// A finished result sits in an output register, so a new item can be
// accepted while it waits. Configuration registers
// (index order: gain_p, gain_i, gain_d, deriv_smoothing, error_smoothing,
// drive_smoothing, drive_limit) must only be written while the block is
// idle, since cfg_ready_o stays high; index 7 is ignored. Smoothing weights
// above 65536 act as 65536.
module incremental_pid_filtered_clamped #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ipidfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ipidfc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // error sample input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [31:0]                   error_sample_i,
  // drive output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   drive_value_o
);

  localparam int unsigned AW = ipidfc_pkg::ACC_W;
  localparam int unsigned OW = ipidfc_pkg::OPD_W;
  localparam int unsigned MW = ipidfc_pkg::MAG_W;
  localparam int unsigned CW = ipidfc_pkg::MCAND_W;
  localparam int unsigned WW = ipidfc_pkg::WEIGHT_W;

  // increment limit, 50 in Q(31-F).F
  localparam logic signed [AW-1:0] DLIM_POS =
    AW'(ipidfc_pkg::DELTA_LIMIT_INT) << FRAC_BITS;
  localparam logic signed [AW-1:0] DLIM_NEG = -DLIM_POS;
  localparam logic signed [AW-1:0] S32_MAX  = AW'(32'sh7fff_ffff);
  localparam logic signed [AW-1:0] S32_MIN  = AW'($signed(32'h8000_0000));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FE,       // filtered error
    ST_P,
    ST_I,
    ST_DRAW,     // raw derivative product
    ST_DBLEND,   // derivative smoothing
    ST_CLAMP,    // increment clamp
    ST_DRIVE,    // add to last drive, limit
    ST_OBLEND,   // output smoothing
    ST_OUT
  } state_e;

  // symmetric clamp to +/-lim
  function automatic logic signed [31:0] clamp_lim(input logic signed [32:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] lp;
    logic signed [32:0] r;
    lp = $signed({2'b00, lim});
    if (v > lp) begin
      r = lp;
    end else if (v < -lp) begin
      r = -lp;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX;
    end else if (v < S32_MIN) begin
      r = S32_MIN;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  state_e state_q;
  logic   issued_q;      // request for the current state sits in the multiplier
  logic   out_valid_q;
  logic   out_load;      // result moves into the output register this cycle
  logic signed [31:0] drive_q;

  // configuration
  logic [30:0]   gain_p_q, gain_i_q, gain_d_q, drive_limit_q;
  logic [WW-1:0] deriv_smoothing_q, error_smoothing_q, drive_smoothing_q;

  // controller history
  logic signed [31:0] last_drive_q, last_fe_q, older_fe_q, last_d_q;

  // per-item working values
  logic signed [31:0]   err_q, fe_q, draw_q, d_q, dlt_q, u_q, y_q;
  logic signed [AW-1:0] sum_q;

  // multiplier interface
  ipidfc_pkg::mac_req_t mac_req;
  ipidfc_pkg::mac_rsp_t mac_rsp;

  logic signed [OW-1:0] opd;
  logic signed [MW-1:0] opd_ext;
  logic [CW-1:0]        mcand;
  logic                 gain_shift;
  logic                 mul_state;

  logic signed [31:0]   res32;
  logic signed [31:0]   fe_next, d_next, dlt_next, u_next, y_next;
  logic signed [AW-1:0] sum_with_d;

  ipidfc_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  // Operand select. Every blend w*x + (1-w)*y is done as y + w*(x-y).
  always_comb begin
    opd        = '0;
    mcand      = '0;
    gain_shift = 1'b0;
    unique case (state_q)
      ST_FE: begin
        opd   = OW'(err_q) - OW'(last_fe_q);
        mcand = ipidfc_pkg::wclamp(error_smoothing_q);
      end
      ST_P: begin
        opd        = OW'(fe_q) - OW'(last_fe_q);
        mcand      = gain_p_q;
        gain_shift = 1'b1;
      end
      ST_I: begin
        opd        = OW'(fe_q);
        mcand      = gain_i_q;
        gain_shift = 1'b1;
      end
      ST_DRAW: begin
        // second difference of the filtered error
        opd        = OW'(fe_q) - (OW'(last_fe_q) <<< 1) + OW'(older_fe_q);
        mcand      = gain_d_q;
        gain_shift = 1'b1;
      end
      ST_DBLEND: begin
        opd   = OW'(draw_q) - OW'(last_d_q);
        mcand = ipidfc_pkg::wclamp(deriv_smoothing_q);
      end
      ST_OBLEND: begin
        opd   = OW'(u_q) - OW'(last_drive_q);
        mcand = ipidfc_pkg::wclamp(drive_smoothing_q);
      end
      default: begin
        opd = '0;
      end
    endcase

    mul_state = state_q inside {ST_FE, ST_P, ST_I, ST_DRAW, ST_DBLEND, ST_OBLEND};

    // sign-magnitude split for the unsigned multiplier
    opd_ext            = MW'(opd);
    mac_req.start      = mul_state && !issued_q;
    mac_req.neg        = opd[OW-1];
    mac_req.gain_shift = gain_shift;
    mac_req.mag        = opd[OW-1] ? unsigned'(-opd_ext) : unsigned'(opd_ext);
    mac_req.mcand      = mcand;
  end

  // Result handling. Blended values land back inside 32 bits, so the filter
  // updates wrap safely; the output blend delta can need 33 bits ahead of its
  // clamp, so it keeps them.
  always_comb begin
    res32      = mac_rsp.result[31:0];
    fe_next    = last_fe_q + res32;
    d_next     = last_d_q + res32;
    sum_with_d = sum_q + AW'(last_d_q) + mac_rsp.result;
    if (sum_q > DLIM_POS) begin
      dlt_next = DLIM_POS[31:0];
    end else if (sum_q < DLIM_NEG) begin
      dlt_next = DLIM_NEG[31:0];
    end else begin
      dlt_next = sum_q[31:0];
    end
    u_next = clamp_lim(33'(last_drive_q) + 33'(dlt_q), drive_limit_q);
    y_next = clamp_lim(33'(last_drive_q) + $signed(mac_rsp.result[32:0]), drive_limit_q);
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      issued_q          <= 1'b0;
      out_valid_q       <= 1'b0;
      drive_q           <= '0;
      gain_p_q          <= 31'd39322;
      gain_i_q          <= 31'd655;
      gain_d_q          <= 31'd459;
      deriv_smoothing_q <= WW'(13107);
      error_smoothing_q <= WW'(19661);
      drive_smoothing_q <= WW'(26214);
      drive_limit_q     <= 31'd6553600;
      last_drive_q      <= '0;
      last_fe_q         <= '0;
      older_fe_q        <= '0;
      last_d_q          <= '0;
      err_q             <= '0;
      fe_q              <= '0;
      draw_q            <= '0;
      d_q               <= '0;
      dlt_q             <= '0;
      u_q               <= '0;
      y_q               <= '0;
      sum_q             <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ipidfc_pkg::REG_GAIN_P:          gain_p_q          <= cfg_data_i[30:0];
          ipidfc_pkg::REG_GAIN_I:          gain_i_q          <= cfg_data_i[30:0];
          ipidfc_pkg::REG_GAIN_D:          gain_d_q          <= cfg_data_i[30:0];
          ipidfc_pkg::REG_DERIV_SMOOTHING: deriv_smoothing_q <= cfg_data_i[WW-1:0];
          ipidfc_pkg::REG_ERROR_SMOOTHING: error_smoothing_q <= cfg_data_i[WW-1:0];
          ipidfc_pkg::REG_DRIVE_SMOOTHING: drive_smoothing_q <= cfg_data_i[WW-1:0];
          ipidfc_pkg::REG_DRIVE_LIMIT:     drive_limit_q     <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (mac_req.start) begin
        issued_q <= 1'b1;
      end else if (mac_rsp.done) begin
        issued_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            err_q   <= error_sample_i;
            state_q <= ST_FE;
          end
        end
        ST_FE: begin
          if (mac_rsp.done) begin
            fe_q    <= fe_next;
            state_q <= ST_P;
          end
        end
        ST_P: begin
          if (mac_rsp.done) begin
            sum_q   <= mac_rsp.result;
            state_q <= ST_I;
          end
        end
        ST_I: begin
          if (mac_rsp.done) begin
            sum_q   <= sum_q + mac_rsp.result;
            state_q <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (mac_rsp.done) begin
            draw_q  <= sat32(mac_rsp.result);
            state_q <= ST_DBLEND;
          end
        end
        ST_DBLEND: begin
          if (mac_rsp.done) begin
            d_q     <= d_next;
            sum_q   <= sum_with_d;   // P + I + smoothed D at full width
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          dlt_q   <= dlt_next;
          state_q <= ST_DRIVE;
        end
        ST_DRIVE: begin
          u_q     <= u_next;
          state_q <= ST_OBLEND;
        end
        ST_OBLEND: begin
          if (mac_rsp.done) begin
            y_q     <= y_next;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // wait for the output register to free up, then commit history
          if (out_load) begin
            drive_q      <= y_q;
            older_fe_q   <= last_fe_q;
            last_fe_q    <= fe_q;
            last_d_q     <= d_q;
            last_drive_q <= y_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;

endmodule

/* design/ipidfc_mac.sv */
module ipidfc_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipidfc_pkg::mac_req_t req_i,
  output ipidfc_pkg::mac_rsp_t rsp_o
);

  localparam int unsigned AW = ipidfc_pkg::ACC_W;
  localparam int unsigned DW = ipidfc_pkg::DIG_W;
  localparam int unsigned MW = ipidfc_pkg::MAG_W;
  localparam int unsigned CW = ipidfc_pkg::MCAND_W;
  localparam int unsigned PW = DW + CW;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_HI,
    MAC_LO,
    MAC_FIN
  } mac_state_e;

  mac_state_e           state_q;
  logic [MW-1:0]        mag_q;
  logic [CW-1:0]        mcand_q;
  logic                 neg_q;
  logic                 gain_shift_q;
  logic                 done_q;
  logic [AW-1:0]        acc_q;
  logic signed [AW-1:0] result_q;

  logic [DW-1:0]        digit;
  logic [PW-1:0]        prod;
  logic [AW-1:0]        acc_next;
  logic signed [AW-1:0] signed_acc;
  logic signed [AW-1:0] shifted;

  // high digit first, so the accumulator shifts left each step
  always_comb begin
    digit      = (state_q == MAC_HI) ? mag_q[MW-1 -: DW] : mag_q[DW-1:0];
    prod       = PW'(digit) * PW'(mcand_q);
    acc_next   = (acc_q << DW) + AW'(prod);
    signed_acc = neg_q ? -$signed(acc_q) : $signed(acc_q);
    shifted    = gain_shift_q ? (signed_acc >>> FRAC_BITS)
                              : (signed_acc >>> ipidfc_pkg::WEIGHT_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= MAC_IDLE;
      mag_q        <= '0;
      mcand_q      <= '0;
      neg_q        <= 1'b0;
      gain_shift_q <= 1'b0;
      done_q       <= 1'b0;
      acc_q        <= '0;
      result_q     <= '0;
    end else begin
      done_q <= (state_q == MAC_FIN);
      unique case (state_q)
        MAC_IDLE: begin
          if (req_i.start) begin
            mag_q        <= req_i.mag;
            mcand_q      <= req_i.mcand;
            neg_q        <= req_i.neg;
            gain_shift_q <= req_i.gain_shift;
            acc_q        <= '0;
            state_q      <= MAC_HI;
          end
        end
        MAC_HI: begin
          acc_q   <= acc_next;
          state_q <= MAC_LO;
        end
        MAC_LO: begin
          acc_q   <= acc_next;
          state_q <= MAC_FIN;
        end
        MAC_FIN: begin
          result_q <= shifted;   // floor, since the sign is applied before the shift
          state_q  <= MAC_IDLE;
        end
        default: state_q <= MAC_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 79;
  localparam int unsigned PLAN_ROWS = 35;
  localparam longint DELTA_LIM = longint'(ipidfc_pkg::DELTA_LIMIT_INT) <<< FRAC_BITS;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [ipidfc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // index with no register

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_e;
  typedef enum logic [1:0] {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_e;

  // one row of the directed plan: either an error sample or a register write
  typedef struct packed {
    step_kind_e kind;
    logic [ipidfc_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0] value;
    logic check;                 // drive value typed in below
    logic signed [31:0] want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ipidfc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ipidfc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] error_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] drive_value_o;

  incremental_pid_filtered_clamped #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .error_sample_i(error_sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_value_o(drive_value_o)
  );

  always #1 clk_i = ~clk_i;

  // Controller copy: registers at their reset values, history cleared.
  logic [30:0] k_p = 31'd39322;
  logic [30:0] k_i = 31'd655;
  logic [30:0] k_d = 31'd459;
  logic [16:0] w_deriv = 17'd13107;
  logic [16:0] w_err = 17'd19661;
  logic [16:0] w_drive = 17'd26214;
  logic [30:0] lim_drive = 31'd6553600;
  logic signed [31:0] drive_last = '0;
  logic signed [31:0] filt_last = '0;
  logic signed [31:0] filt_older = '0;
  logic signed [31:0] deriv_last = '0;

  logic signed [31:0] drive_expect_q[$];
  pace_e pace = PACE_FULL;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned samples_sent = 0;
  int unsigned writes_done = 0;
  int unsigned drives_seen = 0;
  logic signed [31:0] held_sample = '0;
  plan_row_t directed_plan [PLAN_ROWS];

  // a * g >> FRAC_BITS, floor; full width so the wide P and I terms survive
  function automatic longint scale_by_gain(input longint a, input logic [30:0] g);
    logic signed [127:0] wa;
    logic signed [127:0] wg;
    logic signed [127:0] prod;
    wa = a;
    wg = {97'd0, g};
    prod = (wa * wg) >>> FRAC_BITS;
    return prod[63:0];
  endfunction

  // low-pass blend w*x + (1-w)*y in Q1.16, floor; weight saturates at one
  function automatic longint mix(input longint x, input longint y, input logic [16:0] w);
    longint wt;
    wt = (w > 17'(ipidfc_pkg::WEIGHT_ONE)) ? longint'(ipidfc_pkg::WEIGHT_ONE) : longint'(w);
    return (wt * x + (longint'(ipidfc_pkg::WEIGHT_ONE) - wt) * y) >>> ipidfc_pkg::WEIGHT_BITS;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One control step: returns the new drive and shifts the error history.
  function automatic logic signed [31:0] step_drive(input logic signed [31:0] e);
    longint fe, p_inc, i_inc, d_raw, d_inc, delta, u, y, lim;
    lim = longint'(lim_drive);
    fe = mix(e, filt_last, w_err);
    p_inc = scale_by_gain(fe - filt_last, k_p);
    i_inc = scale_by_gain(fe, k_i);
    d_raw = scale_by_gain(fe - 2 * longint'(filt_last) + filt_older, k_d);
    // only the raw D product saturates; P and I stay wide until the delta clamp
    if (d_raw > S32_MAX) d_raw = S32_MAX;
    if (d_raw < S32_MIN) d_raw = S32_MIN;
    d_inc = mix(d_raw, deriv_last, w_deriv);
    delta = clamp_mag(p_inc + i_inc + d_inc, DELTA_LIM);
    u = clamp_mag(drive_last + delta, lim);
    y = clamp_mag(mix(u, drive_last, w_drive), lim);
    filt_older = filt_last;
    filt_last = fe[31:0];
    deriv_last = d_inc[31:0];
    drive_last = y[31:0];
    return y[31:0];
  endfunction

  function automatic void apply_reg(input logic [ipidfc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      ipidfc_pkg::REG_GAIN_P:          k_p = data[30:0];
      ipidfc_pkg::REG_GAIN_I:          k_i = data[30:0];
      ipidfc_pkg::REG_GAIN_D:          k_d = data[30:0];
      ipidfc_pkg::REG_DERIV_SMOOTHING: w_deriv = data[16:0];
      ipidfc_pkg::REG_ERROR_SMOOTHING: w_err = data[16:0];
      ipidfc_pkg::REG_DRIVE_SMOOTHING: w_drive = data[16:0];
      ipidfc_pkg::REG_DRIVE_LIMIT:     lim_drive = data[30:0];
      default: ;   // unknown index leaves everything alone
    endcase
  endfunction

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned src_gap_pct();
    case (pace)
      PACE_SRC_GAPS: return 76;
      PACE_BOTH:     return 7;
      default:       return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct();
    case (pace)
      PACE_SINK_STALLS: return 76;
      PACE_BOTH:        return 7;
      default:          return 0;
    endcase
  endfunction

  // gains and limit: zero, all ones, the reset value, small, or anything
  function automatic logic [31:0] pick_wide(input logic [31:0] dflt);
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return dflt;
      3:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  // weights: zero, exactly one, the reset value, above one, a fraction, or random bits
  function automatic logic [31:0] pick_weight(input logic [31:0] dflt);
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'(ipidfc_pkg::WEIGHT_ONE);
      2:       return dflt;
      3:       return $urandom_range(32'h1_0001, 32'h1_FFFF);
      4:       return $urandom();
      default: return $urandom_range(0, ipidfc_pkg::WEIGHT_ONE);
    endcase
  endfunction

  // error samples: random bits, moderate magnitudes, extremes, or the last sample held
  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom();
      4, 5, 6:    s = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      7: begin
        case ($urandom_range(0, 3))
          0:       s = 32'sh7FFF_FFFF;
          1:       s = 32'sh8000_0000;
          2:       s = '0;
          default: s = -32'sd1;
        endcase
      end
      default: s = held_sample;   // steady error for a few steps
    endcase
    held_sample = s;
    return s;
  endfunction

  // Call at a falling edge. Leaves valid high on return; a settle lowers it,
  // and the next call lowers it only for a source gap.
  task automatic push_sample(input logic signed [31:0] s, input logic check,
                             input logic signed [31:0] want);
    logic signed [31:0] predicted;
    while (roll(src_gap_pct())) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    error_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = step_drive(s);
    drive_expect_q.push_back(check ? want : predicted);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Call at a falling edge; leaves cfg_valid_i high for back-to-back writes.
  task automatic write_reg(input logic [ipidfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    writes_done++;
    @(negedge clk_i);
  endtask

  // Every sample yields a drive, so an empty queue means the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver side: ready changes on the falling edge only.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && !roll(sink_stall_pct());
  end

  // Drive checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      drives_seen++;
      if (drive_expect_q.size() == 0) begin
        $error("drive_value with nothing expected: actual %0d", drive_value_o);
        fail_count++;
      end else begin
        logic signed [31:0] exp_drive;
        exp_drive = drive_expect_q.pop_front();
        if (drive_value_o !== exp_drive) begin
          $error("drive_value mismatch: expected %0d, actual %0d", exp_drive, drive_value_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drives outstanding",
               cycle_count, drive_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    bit writing;
    plan_row_t row;
    writing = 1'b0;

    // Directed plan. Typed drive values only where the answer is obvious:
    // straight after reset, and under a zero drive limit.
    directed_plan = '{
      // reset state, zero error: nothing moves
      '{STEP_SAMPLE, 3'd0, 32'h0000_0000, 1'b1, 32'sd0},
      // sample extremes with reset gains
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h8000_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h0000_0001, 1'b0, 32'sd0},
      // input weight above one, output weight exactly one, huge P and D
      '{STEP_WRITE, ipidfc_pkg::REG_ERROR_SMOOTHING, 32'h0001_FFFF, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_DRIVE_SMOOTHING, 32'h0001_0000, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_GAIN_P, 32'hFFFF_FFFF, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_GAIN_D, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      // wide P, saturated D, increment clamped at +/-50
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h8000_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      // limit dropped under the stored drive
      '{STEP_WRITE, ipidfc_pkg::REG_DRIVE_LIMIT, 32'h0001_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h8000_0000, 1'b0, 32'sd0},
      // zero limit pins the drive at zero
      '{STEP_WRITE, ipidfc_pkg::REG_DRIVE_LIMIT, 32'h0000_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b1, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h8000_0000, 1'b1, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h1234_5678, 1'b1, 32'sd0},
      // unknown index must not touch the limit
      '{STEP_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b1, 32'sd0},
      // full integral gain, zero derivative and error weights, widest limit
      '{STEP_WRITE, ipidfc_pkg::REG_GAIN_I, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_DERIV_SMOOTHING, 32'h0000_0000, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_DRIVE_LIMIT, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_ERROR_SMOOTHING, 32'h0000_0000, 1'b0, 32'sd0},
      // zero input weight: filtered error frozen
      '{STEP_SAMPLE, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_ERROR_SMOOTHING, 32'h0000_8000, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_DERIV_SMOOTHING, 32'h0001_FFFF, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_DRIVE_SMOOTHING, 32'h0000_0000, 1'b0, 32'sd0},
      // output weight zero: drive holds
      '{STEP_SAMPLE, 3'd0, 32'h8000_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h4000_0000, 1'b0, 32'sd0},
      '{STEP_WRITE, ipidfc_pkg::REG_DRIVE_SMOOTHING, 32'h0001_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'hC000_0000, 1'b0, 32'sd0},
      '{STEP_SAMPLE, 3'd0, 32'h0001_0000, 1'b0, 32'sd0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at full pace; settles before each run of register writes.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = directed_plan[r];
      if (row.kind == STEP_WRITE) begin
        if (!writing) begin
          settle();
          writing = 1'b1;
        end
        write_reg(row.idx, row.value);
      end else begin
        if (writing) begin
          cfg_valid_i <= 1'b0;
          writing = 1'b0;
        end
        push_sample(row.value, row.check, row.want);
      end
    end

    // Random part: each phase picks a pacing mode and a fresh register set.
    // Phase 0 goes back to the reset values at full rate.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      settle();
      pace = pace_e'(ph % 4);
      if (ph == 0) begin
        write_reg(ipidfc_pkg::REG_GAIN_P, 32'd39322);
        write_reg(ipidfc_pkg::REG_GAIN_I, 32'd655);
        write_reg(ipidfc_pkg::REG_GAIN_D, 32'd459);
        write_reg(ipidfc_pkg::REG_DERIV_SMOOTHING, 32'd13107);
        write_reg(ipidfc_pkg::REG_ERROR_SMOOTHING, 32'd19661);
        write_reg(ipidfc_pkg::REG_DRIVE_SMOOTHING, 32'd26214);
        write_reg(ipidfc_pkg::REG_DRIVE_LIMIT, 32'd6553600);
      end else begin
        write_reg(ipidfc_pkg::REG_GAIN_P, pick_wide(32'd39322));
        write_reg(ipidfc_pkg::REG_GAIN_I, pick_wide(32'd655));
        write_reg(ipidfc_pkg::REG_GAIN_D, pick_wide(32'd459));
        write_reg(ipidfc_pkg::REG_DERIV_SMOOTHING, pick_weight(32'd13107));
        write_reg(ipidfc_pkg::REG_ERROR_SMOOTHING, pick_weight(32'd19661));
        write_reg(ipidfc_pkg::REG_DRIVE_SMOOTHING, pick_weight(32'd26214));
        write_reg(ipidfc_pkg::REG_DRIVE_LIMIT, pick_wide(32'd6553600));
        if (roll(40)) write_reg(REG_UNUSED, $urandom());
      end
      cfg_valid_i <= 1'b0;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_sample(pick_sample(), 1'b0, 32'sd0);
      end
    end

    // Wind down: everything taken, then a quiet drain to catch any stray drive.
    in_valid_i <= 1'b0;
    pace = PACE_FULL;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (drive_expect_q.size() != 0) begin
      $error("%0d drive values never arrived", drive_expect_q.size());
      fail_count++;
    end

    $display("Sent %0d error samples over %0d pacing phases, %0d register writes.",
             samples_sent, PHASES, writes_done);
    $display("Checked %0d drive values in %0d cycles, %0d failures.",
             drives_seen, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ipidfc_pkg.sv
design/ipidfc_mac.sv
design/incremental_pid_filtered_clamped.sv
tb/testbench.sv
